[hdl/xwsc_pkg.sv]
// ----------------------------------------------------------------------------
// xwsc_pkg
// Shared constants and types for the id widening and stripe classifier.
// ----------------------------------------------------------------------------
package xwsc_pkg;

  localparam int STRIDE   = 16;
  localparam int SLOT_W   = $clog2(STRIDE);
  localparam int CMP_W    = (SLOT_W > 4) ? SLOT_W : 4;

  localparam int XID_W    = 32;
  localparam int FULL_W   = 64;
  localparam int OWN_W    = 4;
  localparam int IN_W     = XID_W + FULL_W;
  localparam int OUT_W    = FULL_W + 8;
  localparam int CIDX_W   = 2;

  localparam logic [CIDX_W-1:0] REG_STRIPE_ACTIVE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_OWN_SLOT      = 2'd1;
  localparam logic [CIDX_W-1:0] REG_FLOOR_ID      = 2'd2;

  typedef struct packed {
    logic              stripe_active;
    logic [OWN_W-1:0]  own_slot;
    logic [FULL_W-1:0] floor_id;
  } cfg_t;

  typedef struct packed {
    logic              foreign_class_cheap;
    logic              provably_foreign;
    logic              is_mine;
    logic [3:0]        origin_slot;
    logic              origin_valid;
    logic [FULL_W-1:0] widened_full;
  } result_t;

endpackage

[hdl/xwsc_widen.sv]
// ----------------------------------------------------------------------------
// xwsc_widen
// Widens a 32-bit id to 64 bits in a -2^31..+2^31-1 window around next.
// ----------------------------------------------------------------------------
module xwsc_widen (
  input  logic [xwsc_pkg::XID_W-1:0]  raw_xid,
  input  logic [xwsc_pkg::FULL_W-1:0] centre_id,
  output logic [xwsc_pkg::FULL_W-1:0] widened_full
);

  logic [31:0] d;
  logic        ahead;
  logic [63:0] sum;
  logic [32:0] back;
  logic [64:0] diff;
  logic        special;

  assign special = (raw_xid < 32'd3) || (centre_id == 64'd0);
  assign d       = raw_xid - centre_id[31:0];
  assign ahead   = ~d[31];
  assign sum     = centre_id + {32'd0, d};
  assign back    = 33'h1_0000_0000 - {1'b0, d};
  assign diff    = {1'b0, centre_id} - {32'd0, back};

  always_comb begin
    priority if (special) begin
      widened_full = '0;
    end else if (ahead) begin
      widened_full = sum;
    end else if (diff[64]) begin
      widened_full = '0;
    end else begin
      widened_full = diff[63:0];
    end
  end

endmodule

[hdl/xwsc_classify.sv]
// ----------------------------------------------------------------------------
// xwsc_classify
// Origin slot and ownership flags for a widened id.
// ----------------------------------------------------------------------------
module xwsc_classify (
  input  xwsc_pkg::cfg_t              cfg,
  input  logic [xwsc_pkg::XID_W-1:0]  raw_xid,
  input  logic [xwsc_pkg::FULL_W-1:0] widened_full,
  output xwsc_pkg::result_t           res
);

  logic                       act;
  logic                       normal;
  logic                       ovalid;
  logic                       cheap;
  logic [xwsc_pkg::CMP_W-1:0] own_ext;
  logic [xwsc_pkg::CMP_W-1:0] slot_ext;
  logic [xwsc_pkg::CMP_W-1:0] cls_ext;

  assign own_ext  = xwsc_pkg::CMP_W'(cfg.own_slot);
  assign slot_ext = xwsc_pkg::CMP_W'(widened_full[xwsc_pkg::SLOT_W-1:0]);
  assign cls_ext  = xwsc_pkg::CMP_W'(raw_xid[xwsc_pkg::SLOT_W-1:0]);

  assign act    = cfg.stripe_active && (cfg.floor_id != '0) &&
                  (32'(cfg.own_slot) < xwsc_pkg::STRIDE);
  assign normal = raw_xid >= 32'd3;
  assign ovalid = act && (widened_full != '0) && (widened_full >= cfg.floor_id);
  assign cheap  = act && normal && (cls_ext != own_ext);

  always_comb begin
    res.widened_full        = widened_full;
    res.origin_valid        = ovalid;
    res.origin_slot         = ovalid ? (widened_full[3:0] & 4'(xwsc_pkg::STRIDE - 1)) : 4'd0;
    res.is_mine             = ovalid && (slot_ext == own_ext);
    res.provably_foreign    = cheap && ovalid;
    res.foreign_class_cheap = cheap;
  end

endmodule

[hdl/xid_window_widen_and_stripe_classify_core.sv]
// ----------------------------------------------------------------------------
// xid_window_widen_and_stripe_classify_core
// Transaction id widening and stripe classification, one result per id.
//
// s_tdata carries a 32-bit id and the 64-bit next id; m_tdata returns the
// widened id with its origin slot and ownership flags. Configuration is
// written through cfg_valid/cfg_index/cfg_data, always ready. The user
// must write it only while the stream is idle; the block does not check.
// Each transfer is captured in an input register and its result is then
// registered in an output register that drives m_tvalid. A 32-bit and a
// 33-bit subtract, a 64-bit add and subtract and the floor compare sit
// between the two registers, so one id is taken every cycle while m_tready
// stays high. Reset clears both valid flags and the configuration registers.
// When m_tready is low the output register holds; the input register
// still fills, and s_tready drops only once both registers are occupied.
// ----------------------------------------------------------------------------
module xid_window_widen_and_stripe_classify_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [xwsc_pkg::IN_W-1:0]       s_tdata,   // raw_xid[31:0], centre_id[95:32]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [xwsc_pkg::OUT_W-1:0]      m_tdata,   // widened_full[63:0], origin_valid[64],
                                                     // origin_slot[68:65], is_mine[69],
                                                     // provably_foreign[70],
                                                     // foreign_class_cheap[71]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xwsc_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [xwsc_pkg::FULL_W-1:0]     cfg_data
);

  xwsc_pkg::cfg_t               cfg;
  logic                         in_valid;
  logic [xwsc_pkg::XID_W-1:0]   in_xid;
  logic [xwsc_pkg::FULL_W-1:0]  in_next;
  logic [xwsc_pkg::FULL_W-1:0]  widened;
  xwsc_pkg::result_t            res_next;
  xwsc_pkg::result_t            res;
  logic                         out_valid;
  logic                         out_adv;
  logic                         in_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        xwsc_pkg::REG_STRIPE_ACTIVE: cfg.stripe_active <= cfg_data[0];
        xwsc_pkg::REG_OWN_SLOT:      cfg.own_slot      <= cfg_data[xwsc_pkg::OWN_W-1:0];
        xwsc_pkg::REG_FLOOR_ID:      cfg.floor_id      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_adv  = !out_valid || m_tready;
  assign in_adv   = !in_valid || out_adv;
  assign s_tready = in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_adv) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && s_tvalid) begin
      in_xid  <= s_tdata[xwsc_pkg::XID_W-1:0];
      in_next <= s_tdata[xwsc_pkg::IN_W-1:xwsc_pkg::XID_W];
    end
  end

  xwsc_widen u_widen (
    .raw_xid      (in_xid),
    .centre_id    (in_next),
    .widened_full (widened)
  );

  xwsc_classify u_classify (
    .cfg          (cfg),
    .raw_xid      (in_xid),
    .widened_full (widened),
    .res          (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {res.foreign_class_cheap, res.provably_foreign, res.is_mine,
                     res.origin_slot, res.origin_valid, res.widened_full};

  // checks
  a_mine_needs_origin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[69] |-> m_tdata[64])
    else $error("is_mine without origin_valid");

  a_foreign_subset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[70] |-> m_tdata[71] && m_tdata[64])
    else $error("provably_foreign without cheap class or origin");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[64] |-> m_tdata[68:65] == 4'd0)
    else $error("origin_slot set without origin_valid");

  a_origin_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64] |-> m_tdata[63:0] != 64'd0)
    else $error("origin_valid on a failed widening");

endmodule

[tb/xid_window_widen_and_stripe_classify_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xid_window_widen_and_stripe_classify_core_tb
// Streams transaction ids with their window centres through the classifier
// under a series of stripe settings. Every result transfer is checked field
// by field against a local prediction of the widening and slot flags. Both
// stream sides idle at random, and the receiver also holds off for long
// stretches so that the core backs up.
// ----------------------------------------------------------------------------
module xid_window_widen_and_stripe_classify_core_tb;

  typedef struct packed {
    logic [xwsc_pkg::FULL_W-1:0] centre_id;
    logic [xwsc_pkg::XID_W-1:0]  raw_xid;
  } id_item_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [xwsc_pkg::IN_W-1:0]     s_tdata = '0;   // raw_xid, centre_id
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [xwsc_pkg::OUT_W-1:0]    m_tdata;        // widened_full, origin_valid, origin_slot,
                                                 // is_mine, provably_foreign,
                                                 // foreign_class_cheap
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [xwsc_pkg::CIDX_W-1:0]   cfg_index = '0;
  logic [xwsc_pkg::FULL_W-1:0]   cfg_data = '0;

  id_item_t                      pending_ids[$];
  xwsc_pkg::result_t             expected_results[$];

  logic                          cur_active = 1'b0;
  logic [xwsc_pkg::OWN_W-1:0]    cur_own = '0;
  logic [xwsc_pkg::FULL_W-1:0]   cur_floor = '0;

  logic                          no_idle = 1'b0;
  logic                          in_accepted = 1'b0;
  logic                          out_accepted = 1'b0;
  int                            send_gap = 0;
  int                            recv_gap = 0;
  int                            long_hold = 0;
  int                            results_seen = 0;
  int                            results_checked = 0;
  int                            mismatches = 0;
  int                            settings_run = 0;
  xwsc_pkg::result_t             got_result;
  xwsc_pkg::result_t             want_result;

  xid_window_widen_and_stripe_classify_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic xwsc_pkg::result_t classify_xid(
      input logic [xwsc_pkg::XID_W-1:0] raw,
      input logic [xwsc_pkg::FULL_W-1:0] centre);
    xwsc_pkg::result_t           r;
    logic [31:0]                 delta;
    logic [xwsc_pkg::FULL_W-1:0] back;
    logic [xwsc_pkg::FULL_W-1:0] wide;
    logic [xwsc_pkg::FULL_W-1:0] slot_full;
    logic                        active;
    logic                        normal;
    logic                        cheap;
    r = '0;
    wide = '0;
    delta = raw - centre[31:0];
    back = 64'h1_0000_0000 - {32'h0, delta};
    normal = raw >= 32'd3;
    if (normal && centre != '0) begin
      if (!delta[31]) begin
        wide = centre + {32'h0, delta};
      end else if (centre >= back) begin
        wide = centre - back;
      end
    end
    active = cur_active && cur_floor != '0 && cur_own < xwsc_pkg::STRIDE;
    slot_full = wide & 64'(xwsc_pkg::STRIDE - 1);
    r.widened_full = wide;
    r.origin_valid = active && wide != '0 && wide >= cur_floor;
    r.origin_slot = r.origin_valid ? slot_full[3:0] : 4'd0;
    r.is_mine = r.origin_valid && slot_full == 64'(cur_own);
    cheap = active && normal && (raw & 32'(xwsc_pkg::STRIDE - 1)) != 32'(cur_own);
    r.foreign_class_cheap = cheap;
    r.provably_foreign = cheap && r.origin_valid;
    return r;
  endfunction

  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic id_item_t random_id();
    id_item_t    it;
    logic [31:0] delta;
    case ($urandom_range(0, 5))
      0: it.centre_id = 64'($urandom_range(0, 8));
      1: it.centre_id = ~64'h0 - 64'($urandom_range(0, 8));
      2: it.centre_id = cur_floor + 64'($urandom) - 64'h8000_0000;
      3: it.centre_id = {32'($urandom_range(0, 3)), 32'($urandom)};
      default: it.centre_id = {32'($urandom), 32'($urandom)};
    endcase
    case ($urandom_range(0, 7))
      0: delta = 32'h0;
      1: delta = 32'h7fff_ffff;
      2: delta = 32'h8000_0000;
      3: delta = 32'hffff_ffff;
      4: delta = 32'($urandom_range(0, 64)) - 32'd32;
      default: delta = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0: it.raw_xid = $urandom_range(0, 2);
      1, 2: it.raw_xid = $urandom;
      default: it.raw_xid = it.centre_id[31:0] + delta;
    endcase
    return it;
  endfunction

  task automatic queue_id(input logic [xwsc_pkg::XID_W-1:0] raw,
                          input logic [xwsc_pkg::FULL_W-1:0] centre);
    id_item_t it;
    it.raw_xid = raw;
    it.centre_id = centre;
    pending_ids.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_ids.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [xwsc_pkg::CIDX_W-1:0] idx,
                           input logic [xwsc_pkg::FULL_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      xwsc_pkg::REG_STRIPE_ACTIVE: cur_active = value[0];
      xwsc_pkg::REG_OWN_SLOT:      cur_own = value[xwsc_pkg::OWN_W-1:0];
      xwsc_pkg::REG_FLOOR_ID:      cur_floor = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // sender: one item per transfer, random gap after each
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_accepted) send_gap = draw_gap();
      if (s_tvalid && !in_accepted) begin
        s_tvalid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_ids.size() != 0) begin
        s_tdata  <= pending_ids.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus two long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_accepted) begin
        results_seen++;
        recv_gap = draw_gap();
        if (results_seen == 400 || results_seen == 1400) long_hold = 300;
      end
      if (long_hold > 0) begin
        long_hold--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    in_accepted  <= !rst && s_tvalid && s_tready;
    out_accepted <= !rst && m_tvalid && m_tready;
    if (!rst && s_tvalid && s_tready)
      expected_results.push_back(classify_xid(s_tdata[xwsc_pkg::XID_W-1:0],
                                              s_tdata[xwsc_pkg::IN_W-1:xwsc_pkg::XID_W]));
    if (!rst && m_tvalid && m_tready) begin
      got_result = m_tdata;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: 0x%0h", m_tdata);
        mismatches++;
      end else begin
        want_result = expected_results.pop_front();
        results_checked++;
        check_field("widened_full", want_result.widened_full, got_result.widened_full);
        check_field("origin_valid", 64'(want_result.origin_valid), 64'(got_result.origin_valid));
        check_field("origin_slot", 64'(want_result.origin_slot), 64'(got_result.origin_slot));
        check_field("is_mine", 64'(want_result.is_mine), 64'(got_result.is_mine));
        check_field("provably_foreign", 64'(want_result.provably_foreign),
                    64'(got_result.provably_foreign));
        check_field("foreign_class_cheap", 64'(want_result.foreign_class_cheap),
                    64'(got_result.foreign_class_cheap));
      end
    end
  end

  initial begin
    logic [xwsc_pkg::FULL_W-1:0] rnd;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset: inactive
    queue_id(32'h0000_0105, 64'h100);
    queue_id(32'h0000_0001, 64'h100);
    queue_id(32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    wait_idle();

    write_reg(xwsc_pkg::REG_STRIPE_ACTIVE, 64'h1);
    write_reg(xwsc_pkg::REG_OWN_SLOT, 64'h5);
    write_reg(xwsc_pkg::REG_FLOOR_ID, 64'h1);
    settings_run++;
    queue_id(32'h0, 64'h1234_5678_9abc_def0);
    queue_id(32'h1, 64'h1234_5678_9abc_def0);
    queue_id(32'h2, 64'h1234_5678_9abc_def0);
    queue_id(32'h3, 64'h3);
    queue_id(32'h0000_0064, 64'h0);
    queue_id(32'hffff_fff0, 64'h5);
    queue_id(32'h0000_0010, 64'hffff_ffff_ffff_fff0);
    queue_id(32'h0, 64'hffff_ffff_ffff_fff0);
    queue_id(32'h7fff_ffff, 64'h1_0000_0000);
    queue_id(32'h8000_0000, 64'h1_0000_0000);
    queue_id(32'h8000_0000, 64'h7fff_ffff);
    queue_id(32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    queue_id(32'h0000_0105, 64'h100);
    queue_id(32'h0000_0106, 64'h100);
    queue_id(32'h0000_0003, 64'hffff_ffff_0000_0000);
    queue_id(32'hffff_ffff, 64'h0);
    wait_idle();

    write_reg(xwsc_pkg::REG_OWN_SLOT, 64'hf);
    write_reg(xwsc_pkg::REG_FLOOR_ID, 64'h1_0000_0000);
    settings_run++;
    queue_id(32'h0000_0005, 64'h1_0000_0010);
    queue_id(32'hffff_fff0, 64'h1_0000_0010);
    queue_id(32'h0000_0000, 64'h1_0000_0003);
    queue_id(32'h0000_000f, 64'h1_0000_0003);
    queue_id(32'hffff_ffff, 64'h1_0000_0003);
    wait_idle();

    for (int phase = 0; phase < 10; phase++) begin
      no_idle = (phase % 4 == 3);
      rnd = {32'($urandom), 32'($urandom)};
      rnd[0] = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      write_reg(xwsc_pkg::REG_STRIPE_ACTIVE, rnd);
      case (phase % 3)
        0: write_reg(xwsc_pkg::REG_OWN_SLOT, 64'h0);
        1: write_reg(xwsc_pkg::REG_OWN_SLOT, 64'hf);
        default: write_reg(xwsc_pkg::REG_OWN_SLOT, 64'($urandom_range(0, 15)));
      endcase
      case (phase % 5)
        0: write_reg(xwsc_pkg::REG_FLOOR_ID, 64'h0);
        1: write_reg(xwsc_pkg::REG_FLOOR_ID, 64'h1);
        2: write_reg(xwsc_pkg::REG_FLOOR_ID, 64'hffff_ffff_ffff_ffff);
        3: write_reg(xwsc_pkg::REG_FLOOR_ID, {32'($urandom), 32'($urandom)});
        default: write_reg(xwsc_pkg::REG_FLOOR_ID,
                           {32'($urandom_range(0, 3)), 32'($urandom)});
      endcase
      settings_run++;
      repeat (200) pending_ids.push_back(random_id());
      wait_idle();
    end

    $display("checked %0d result transfers across %0d stripe settings",
             results_checked, settings_run);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("xid_window_widen_and_stripe_classify_core: match");
    end else begin
      $display("xid_window_widen_and_stripe_classify_core: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("xid_window_widen_and_stripe_classify_core: mismatch");
    $finish;
  end

endmodule
